// ----- src/olkdp_pkg.sv -----
// Shared types and constants for the ordered list with keyed delete and split listing.
package olkdp_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 5;

  localparam logic [1:0] CLS_FIRST  = 2'd0;
  localparam logic [1:0] CLS_SECOND = 2'd1;
  localparam logic [1:0] CLS_OTHER  = 2'd2;
  localparam logic [1:0] CLS_NONE   = 2'd3;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_DELETE = 2'd1,
    FN_LIST   = 2'd2,
    FN_SPLIT  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_LISTED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    GRP_ALL    = 2'd0,
    GRP_FIRST  = 2'd1,
    GRP_SECOND = 2'd2
  } group_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_LIST
  } state_e;

  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [KEY_W-1:0]     key;
    logic [1:0]           cls;
    group_e               group;
    logic [COUNT_W-1:0]   first_cnt;
    logic [COUNT_W-1:0]   second_cnt;
    logic                 last;
  } res_t;

endpackage

// ----- src/olkdp_mem.sv -----
// Entry store: one write port, one read port, registered read data.
module olkdp_mem #(
  parameter int unsigned DEPTH = 20,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 66
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/olkdp_ctrl.sv -----
// Sequencer: append, delete scan with compaction, and listing passes over the entry store.
module olkdp_ctrl import olkdp_pkg::*; #(
  parameter int unsigned CAPACITY = 20,
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned IDX_W    = 5,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            func_i,
  input  logic [KEY_W-1:0]      entry_key_i,
  input  logic [1:0]            entry_class_i,
  output logic                  mem_we_o,
  output logic [IDX_W-1:0]      mem_waddr_o,
  output logic [KEY_BITS+1:0]   mem_wdata_o,
  output logic [IDX_W-1:0]      mem_raddr_o,
  input  logic [KEY_BITS+1:0]   mem_rdata_i,
  output res_t                  res_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  state_e              state_q, state_d;
  group_e              grp_q, grp_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]    ra_q, ra_d;
  logic                dv_q, dv_d;
  logic [IDX_W-1:0]    di_q, di_d;
  logic                found_q, found_d;
  logic [1:0]          rcls_q, rcls_d;
  logic                hit_q, hit_d;
  logic [CNT_W-1:0]    ecnt_q, ecnt_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]    first_q, first_d;
  logic [CNT_W-1:0]    second_q, second_d;
  res_t                res_q, res_d;

  logic [KEY_BITS-1:0] in_key;
  logic [1:0]          in_cls;
  logic [KEY_BITS-1:0] rd_key;
  logic [1:0]          rd_cls;
  logic                issue;
  logic                match;

  assign in_key = entry_key_i[KEY_BITS-1:0];
  assign in_cls = (entry_class_i == CLS_NONE) ? CLS_OTHER : entry_class_i;
  assign rd_key = mem_rdata_i[KEY_BITS-1:0];
  assign rd_cls = mem_rdata_i[KEY_BITS+1:KEY_BITS];
  assign issue  = (ra_q < total_q);
  assign match  = (grp_q == GRP_ALL) ||
                  ((grp_q == GRP_FIRST) && (rd_cls == CLS_FIRST)) ||
                  ((grp_q == GRP_SECOND) && (rd_cls == CLS_SECOND));

  assign busy_o      = (state_q != S_IDLE);
  assign mem_raddr_o = ra_q[IDX_W-1:0];
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      grp_q    <= GRP_ALL;
      ra_q     <= '0;
      dv_q     <= 1'b0;
      found_q  <= 1'b0;
      hit_q    <= 1'b0;
      ecnt_q   <= '0;
      total_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      grp_q    <= grp_d;
      ra_q     <= ra_d;
      dv_q     <= dv_d;
      found_q  <= found_d;
      hit_q    <= hit_d;
      ecnt_q   <= ecnt_d;
      total_q  <= total_d;
      first_q  <= first_d;
      second_q <= second_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    di_q   <= di_d;
    rcls_q <= rcls_d;
  end

  always_comb begin
    state_d     = state_q;
    grp_d       = grp_q;
    key_d       = key_q;
    ra_d        = ra_q;
    dv_d        = 1'b0;
    di_d        = di_q;
    found_d     = found_q;
    rcls_d      = rcls_q;
    hit_d       = hit_q;
    ecnt_d      = ecnt_q;
    total_d     = total_q;
    first_d     = first_q;
    second_d    = second_q;
    res_d       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = total_q[IDX_W-1:0];
    mem_wdata_o = {in_cls, in_key};

    if (state_q != S_IDLE) begin
      dv_d = issue;
      di_d = ra_q[IDX_W-1:0];
      if (issue) begin
        ra_d = ra_q + ONE_CNT;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d   = in_key;
          ra_d    = '0;
          found_d = 1'b0;
          hit_d   = 1'b0;
          ecnt_d  = '0;
          unique case (func_e'(func_i))
            FN_APPEND: begin
              res_d.valid = 1'b1;
              res_d.key   = KEY_W'(in_key);
              res_d.cls   = in_cls;
              res_d.group = GRP_ALL;
              res_d.last  = 1'b1;
              if (total_q >= CAP_CNT) begin
                res_d.status = ST_FULL;
              end else begin
                res_d.status = ST_ADDED;
                mem_we_o     = 1'b1;
                total_d      = total_q + ONE_CNT;
                if (in_cls == CLS_FIRST) begin
                  first_d = first_q + ONE_CNT;
                end else if (in_cls == CLS_SECOND) begin
                  second_d = second_q + ONE_CNT;
                end
              end
            end
            FN_DELETE: begin
              state_d = S_DEL;
            end
            FN_LIST: begin
              state_d = S_LIST;
              grp_d   = GRP_ALL;
            end
            FN_SPLIT: begin
              state_d = S_LIST;
              grp_d   = GRP_FIRST;
            end
          endcase
        end
      end

      S_DEL: begin
        if (dv_q) begin
          if (found_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = di_q - IDX_W'(1);
            mem_wdata_o = mem_rdata_i;
          end else if (rd_key == key_q) begin
            found_d = 1'b1;
            rcls_d  = rd_cls;
          end
        end
        if (!issue && !dv_q) begin
          state_d     = S_IDLE;
          res_d.valid = 1'b1;
          res_d.key   = KEY_W'(key_q);
          res_d.group = GRP_ALL;
          res_d.last  = 1'b1;
          if (found_q) begin
            res_d.status = ST_REMOVED;
            res_d.cls    = rcls_q;
            total_d      = total_q - ONE_CNT;
            if (rcls_q == CLS_FIRST && first_q != '0) begin
              first_d = first_q - ONE_CNT;
            end else if (rcls_q == CLS_SECOND && second_q != '0) begin
              second_d = second_q - ONE_CNT;
            end
          end else begin
            res_d.status = ST_NOTFOUND;
            res_d.cls    = CLS_FIRST;
          end
        end
      end

      S_LIST: begin
        if (dv_q && match) begin
          res_d.valid  = 1'b1;
          res_d.status = ST_LISTED;
          res_d.key    = KEY_W'(rd_key);
          res_d.cls    = rd_cls;
          res_d.group  = grp_q;
          res_d.last   = ((grp_q == GRP_ALL) && (CNT_W'(di_q) == total_q - ONE_CNT)) ||
                         ((grp_q == GRP_SECOND) && (ecnt_q + ONE_CNT == second_q));
          hit_d        = 1'b1;
          ecnt_d       = ecnt_q + ONE_CNT;
        end
        if (!issue && !dv_q) begin
          if (!hit_q) begin
            res_d.valid  = 1'b1;
            res_d.status = ST_EMPTY;
            res_d.group  = grp_q;
            res_d.last   = (grp_q != GRP_FIRST);
          end
          if (grp_q == GRP_FIRST) begin
            grp_d  = GRP_SECOND;
            ra_d   = '0;
            hit_d  = 1'b0;
            ecnt_d = '0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.first_cnt  = COUNT_W'(first_d);
    res_d.second_cnt = COUNT_W'(second_d);
  end

`ifndef SYNTHESIS
  a_list_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> !mem_we_o)
    else $error("store written during a listing pass");

  a_counts_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+1)'(first_q) + (CNT_W+1)'(second_q) <= (CNT_W+1)'(total_q)) &&
    (total_q <= CAP_CNT))
    else $error("class counts exceed entry total");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL && state_d == S_IDLE) |=> (res_q.valid && res_q.last))
    else $error("delete ended without a final word");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL && mem_we_o) |-> (CNT_W'(mem_waddr_o) < total_q))
    else $error("compaction write beyond list tail");
`endif

endmodule

// ----- src/ordered_list_keyed_delete_partition.sv -----
// Top level: bounded ordered list with keyed delete and class-split listing.
//
//  channel   | signals                                       | handshake
//  ----------+-----------------------------------------------+------------------------------
//  request   | func_i, entry_key_i, entry_class_i            | taken when start_i && !busy_o
//  result    | status_o, out_key_o, out_class_o, out_group_o,| valid_o for one cycle each
//            | first_count_o, second_count_o, last_result_o  |
//
//  Append: busy_o stays low, its word follows in the cycle after acceptance.
//  Delete and list: busy while the held entries are scanned; split scans them
//  twice, once per group; the single read port walks one entry per cycle.
//  Reset clears the counts and the sequencer; store contents stay undefined.
//  Results cannot be stalled; words leave on valid_o as they are produced.
module ordered_list_keyed_delete_partition import olkdp_pkg::*; #(
  parameter int unsigned CAPACITY = 20,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [KEY_W-1:0]   entry_key_i,
  input  logic [1:0]         entry_class_i,
  output logic               valid_o,
  output logic [2:0]         status_o,
  output logic [KEY_W-1:0]   out_key_o,
  output logic [1:0]         out_class_o,
  output logic [1:0]         out_group_o,
  output logic [COUNT_W-1:0] first_count_o,
  output logic [COUNT_W-1:0] second_count_o,
  output logic               last_result_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DW    = KEY_BITS + 2;

  logic          mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  res_t          res;

  olkdp_mem #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  olkdp_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .entry_key_i   (entry_key_i),
    .entry_class_i (entry_class_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .res_o         (res)
  );

  assign valid_o        = res.valid;
  assign status_o       = res.status;
  assign out_key_o      = res.key;
  assign out_class_o    = res.cls;
  assign out_group_o    = res.group;
  assign first_count_o  = res.first_cnt;
  assign second_count_o = res.second_cnt;
  assign last_result_o  = res.last;

endmodule
